[sv/hsv2a_pkg.sv]
// ============================================================================
// hsv2a_pkg: shared types and constants of the HSV to ARGB converter
// Fixed-point scale factors, channel kinds per hue sector and helpers.
// ============================================================================
`default_nettype none

package hsv2a_pkg;

  // Input and output field widths.
  localparam int unsigned HueW   = 16;
  localparam int unsigned PctW   = 15;
  localparam int unsigned AlphaW = 8;
  localparam int unsigned WordW  = 32;

  // Reduced hue (below 360 degrees) and ramp position widths.
  localparam int unsigned HrW    = 15;
  localparam int unsigned RampW  = 12;

  // Weighted level width: 25600 * 3840 needs 27 bits.
  localparam int unsigned WW     = 27;
  // Product of value and weight: 42 bits.
  localparam int unsigned PW     = 42;
  // Scaled level before the power-of-two shift.
  localparam int unsigned ScW    = 51;
  // Power-of-two part of twice the full-scale denominator.
  localparam int unsigned DenSh  = 29;
  // Level after the power-of-two shift.
  localparam int unsigned YW     = ScW - DenSh;
  // Remaining odd factor of twice the denominator and its reciprocal.
  localparam longint unsigned DivOdd   = 64'd9375;
  localparam int unsigned     RecSh    = 36;
  localparam int unsigned     RecW     = 23;
  localparam logic [RecW-1:0] RecipMul =
    RecW'(((64'd1 << RecSh) + DivOdd - 64'd1) / DivOdd);
  localparam int unsigned     MulW     = YW + RecW;
  localparam int unsigned     QW       = MulW - RecSh;

  // Number of color channels and their slots.
  localparam int unsigned NumChans = 3;
  localparam logic [1:0]  ChRed    = 2'd0;
  localparam logic [1:0]  ChGreen  = 2'd1;
  localparam logic [1:0]  ChBlue   = 2'd2;

  // Fixed-point scales.
  localparam logic [HueW-1:0]  HueFull2 = 16'd46080;  // 720 degrees
  localparam logic [HueW-1:0]  HueFull  = 16'd23040;  // 360 degrees
  localparam logic [HrW-1:0]   HueSect  = 15'd3840;   // 60 degrees
  localparam logic [PctW-1:0]  PctFull  = 15'd25600;  // 100 percent
  localparam logic [WW-1:0]    WFull    = 27'd98304000;
  // Rounding term: the full-scale denominator 25600 * 25600 * 3840.
  localparam logic [ScW-1:0]   DenLevel = 51'd2516582400000;
  localparam logic [7:0]       ChMax    = 8'd255;

  typedef logic [RampW-1:0] ramp_t;

  // How a channel follows the hue within one sector.
  typedef enum logic [1:0] {
    KIND_MAX,
    KIND_MIN,
    KIND_UP,
    KIND_DOWN
  } kind_e;

  // Channel kind for a given sector and channel slot.
  function automatic kind_e chan_kind(input logic [2:0] sector, input logic [1:0] ch);
    kind_e r;
    kind_e g;
    kind_e b;
    kind_e k;
    case (sector)
      3'd0: begin r = KIND_MAX;  g = KIND_UP;   b = KIND_MIN;  end
      3'd1: begin r = KIND_DOWN; g = KIND_MAX;  b = KIND_MIN;  end
      3'd2: begin r = KIND_MIN;  g = KIND_MAX;  b = KIND_UP;   end
      3'd3: begin r = KIND_MIN;  g = KIND_DOWN; b = KIND_MAX;  end
      3'd4: begin r = KIND_UP;   g = KIND_MIN;  b = KIND_MAX;  end
      default: begin r = KIND_MAX; g = KIND_MIN; b = KIND_DOWN; end
    endcase
    case (ch)
      ChRed:   k = r;
      ChGreen: k = g;
      default: k = b;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

[sv/hsv2a_front.sv]
// ============================================================================
// hsv2a_front: hue reduction, clamping and per-channel ramp weights
// Two register stages: reduce hue and cap percentages, then split the hue
// into sector and position and pick the complement weight of each channel.
// ============================================================================
`default_nettype none

module hsv2a_front (
  input  wire logic                                      clk_i,
  input  wire logic [1:0]                                en_i,
  input  wire logic [hsv2a_pkg::HueW-1:0]                hue_i,
  input  wire logic [hsv2a_pkg::PctW-1:0]                sat_i,
  input  wire logic [hsv2a_pkg::PctW-1:0]                val_i,
  input  wire logic [hsv2a_pkg::AlphaW-1:0]              alpha_i,
  output      hsv2a_pkg::ramp_t [hsv2a_pkg::NumChans-1:0] g_o,
  output      logic [hsv2a_pkg::PctW-1:0]                sat_o,
  output      logic [hsv2a_pkg::PctW-1:0]                val_o,
  output      logic [hsv2a_pkg::AlphaW-1:0]              alpha_o
);
  import hsv2a_pkg::*;

  logic [HrW-1:0]    hr_d;
  logic [HrW-1:0]    hr_q;
  logic [PctW-1:0]   s0_q;
  logic [PctW-1:0]   v0_q;
  logic [AlphaW-1:0] a0_q;
  logic [2:0]        sector;
  logic [HrW-1:0]    base;
  ramp_t             frac;
  ramp_t [NumChans-1:0] g_d;
  ramp_t [NumChans-1:0] g_q;
  logic [PctW-1:0]   s1_q;
  logic [PctW-1:0]   v1_q;
  logic [AlphaW-1:0] a1_q;

  // Hue modulo 360 degrees: at most two full turns fit in 16 bits.
  always_comb begin
    if (hue_i >= HueFull2) begin
      hr_d = HrW'(hue_i - HueFull2);
    end else if (hue_i >= HueFull) begin
      hr_d = HrW'(hue_i - HueFull);
    end else begin
      hr_d = HrW'(hue_i);
    end
  end

  // Stage 0: reduced hue and capped saturation and value.
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      hr_q <= hr_d;
      s0_q <= (sat_i > PctFull) ? PctFull : sat_i;
      v0_q <= (val_i > PctFull) ? PctFull : val_i;
      a0_q <= alpha_i;
    end
  end

  // Sector by threshold compares, position within the sector by subtraction.
  always_comb begin
    sector = 3'd0;
    base   = '0;
    for (int k = 1; k < 6; k++) begin
      if (hr_q >= HrW'(k) * HueSect) begin
        sector = 3'(k);
        base   = HrW'(k) * HueSect;
      end
    end
    frac = RampW'(hr_q - base);
  end

  // Complement weight for each channel: 3840 minus its ramp level in the sector.
  always_comb begin
    for (int c = 0; c < NumChans; c++) begin
      case (chan_kind(sector, 2'(c)))
        KIND_MAX: g_d[c] = '0;
        KIND_MIN: g_d[c] = RampW'(HueSect);
        KIND_UP:  g_d[c] = RampW'(HueSect) - frac;
        default:  g_d[c] = frac;
      endcase
    end
  end

  // Stage 1: channel weights with the operands carried along.
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      g_q  <= g_d;
      s1_q <= s0_q;
      v1_q <= v0_q;
      a1_q <= a0_q;
    end
  end

  assign g_o     = g_q;
  assign sat_o   = s1_q;
  assign val_o   = v1_q;
  assign alpha_o = a1_q;

endmodule

`default_nettype wire

[sv/hsv2a_chan.sv]
// ============================================================================
// hsv2a_chan: one color channel from weight to unsaturated byte
// Four register stages: weight, level product, rounding scale, and division
// by the odd part of the denominator through a reciprocal multiply.
// ============================================================================
`default_nettype none

module hsv2a_chan (
  input  wire logic                          clk_i,
  input  wire logic [3:0]                    en_i,
  input  wire hsv2a_pkg::ramp_t              g_i,
  input  wire logic [hsv2a_pkg::PctW-1:0]    sat_i,
  input  wire logic [hsv2a_pkg::PctW-1:0]    val_i,
  output      logic [hsv2a_pkg::QW-1:0]      q_o
);
  import hsv2a_pkg::*;

  logic [WW-1:0]   sg;
  logic [WW-1:0]   w_q;
  logic [PctW-1:0] v2_q;
  logic [PW-1:0]   p_q;
  logic [ScW-1:0]  scaled;
  logic [YW-1:0]   y_q;
  logic [MulW-1:0] prod;
  logic [QW-1:0]   q_q;

  // Stage 2: level weight 25600*3840 - S*(3840 - f).
  assign sg = WW'(sat_i) * WW'(g_i);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      w_q  <= WFull - sg;
      v2_q <= val_i;
    end
  end

  // Stage 3: exact channel level V times weight.
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      p_q <= PW'(v2_q) * PW'(w_q);
    end
  end

  // Stage 4: 510*level plus the rounding term, then the power-of-two divide.
  assign scaled = (ScW'(p_q) << 9) - (ScW'(p_q) << 1) + DenLevel;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      y_q <= scaled[ScW-1:DenSh];
    end
  end

  // Stage 5: divide by the odd factor through the reciprocal.
  assign prod = MulW'(y_q) * MulW'(RecipMul);

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      q_q <= prod[MulW-1:RecSh];
    end
  end

  assign q_o = q_q;

endmodule

`default_nettype wire

[sv/hsv_to_argb_converter.sv]
// ============================================================================
// hsv_to_argb_converter: HSV color with alpha to packed ARGB word
// Seven-stage pipeline with per-stage valid bits and bubble-collapsing stall.
// ============================================================================
// Usage:
//   Input beats arrive on the s_axis channel; each carries hue (1/64 degree),
//   saturation and value (percent, 8 fraction bits) and an alpha byte.
//   Each beat yields one output beat on m_axis holding the ARGB word with
//   alpha in bits 31:24, red 23:16, green 15:8 and blue 7:0.
//   Throughput is one beat per cycle while the output is not stalled.
//   A stage advances when it is empty or the stage after it advances, so
//   bubbles are squeezed out and s_axis_tready stays high while any stage
//   is empty. When the receiver holds m_axis_tready low the final register
//   keeps its beat and the stages behind it fill up, then s_axis_tready
//   drops; no beat is lost or repeated.
//   Reset clears all valid bits; the pipeline is empty and ready afterwards.
// ============================================================================
`default_nettype none

module hsv_to_argb_converter (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // hue_deg[15:0], sat_pct[30:16], val_pct[45:31], alpha[53:46], zero[55:54]
  input  wire logic [55:0] s_axis_tdata,
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // packed_color[31:0]
  output      logic [31:0] m_axis_tdata
);
  import hsv2a_pkg::*;

  localparam int unsigned NumStages = 7;

  logic [NumStages-1:0] valid_d;
  logic [NumStages-1:0] valid_q;
  logic [NumStages:0]   ready;
  ramp_t [NumChans-1:0] g;
  logic [PctW-1:0]      sat1;
  logic [PctW-1:0]      val1;
  logic [AlphaW-1:0]    alpha1;
  logic [AlphaW-1:0]    alpha_q [2:5];
  logic [QW-1:0]        q [NumChans];
  logic [WordW-1:0]     word_d;
  logic [WordW-1:0]     word_q;

  // Stage advance: a stage loads when empty or when its successor loads.
  always_comb begin
    ready[NumStages] = m_axis_tready;
    for (int k = NumStages - 1; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
  end

  // Valid bits travel with the data.
  always_comb begin
    for (int k = 0; k < NumStages; k++) begin
      if (ready[k]) begin
        valid_d[k] = (k == 0) ? s_axis_tvalid : valid_q[(k == 0) ? 0 : k - 1];
      end else begin
        valid_d[k] = valid_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Stages 0 and 1: hue reduction, sector and channel weights.
  hsv2a_front u_front (
    .clk_i   (clk_i),
    .en_i    (ready[1:0]),
    .hue_i   (s_axis_tdata[15:0]),
    .sat_i   (s_axis_tdata[30:16]),
    .val_i   (s_axis_tdata[45:31]),
    .alpha_i (s_axis_tdata[53:46]),
    .g_o     (g),
    .sat_o   (sat1),
    .val_o   (val1),
    .alpha_o (alpha1)
  );

  // Stages 2 to 5: one arithmetic lane per color channel.
  for (genvar c = 0; c < NumChans; c++) begin : g_chan
    hsv2a_chan u_chan (
      .clk_i (clk_i),
      .en_i  (ready[5:2]),
      .g_i   (g[c]),
      .sat_i (sat1),
      .val_i (val1),
      .q_o   (q[c])
    );
  end

  // Alpha delay line alongside the channel lanes.
  always_ff @(posedge clk_i) begin
    if (ready[2]) begin
      alpha_q[2] <= alpha1;
    end
    for (int k = 3; k <= 5; k++) begin
      if (ready[k]) begin
        alpha_q[k] <= alpha_q[k-1];
      end
    end
  end

  // Stage 6: saturate each channel and pack the ARGB word.
  always_comb begin
    word_d[31:24] = alpha_q[5];
    for (int c = 0; c < NumChans; c++) begin
      word_d[8*(2-c) +: 8] = (q[c] > QW'(ChMax)) ? ChMax : q[c][7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready[6]) begin
      word_q <= word_d;
    end
  end

  assign s_axis_tready = ready[0];
  assign m_axis_tvalid = valid_q[NumStages-1];
  assign m_axis_tdata  = word_q;

endmodule

`default_nettype wire
